// File: rtl/slpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slpd_pkg: shared constants and types of the scan line packet deframer
// Holds the packet geometry, the sync pattern and the pixel result record.
// ----------------------------------------------------------------------------
package slpd_pkg;

    localparam int PAYLOAD_BYTES = 512;
    localparam int PACKET_BYTES  = 525;
    localparam int LAST_LINE     = 255;

    localparam int POS_W = 10;
    localparam int HIST_BYTES = 7;

    localparam logic [63:0] SYNC_WORD = 64'h5AA5_FF00_5AA5_FF00;

    localparam int HDR_FRAME_POS_I = 8;
    localparam int HDR_LINE_POS_I  = 9;
    localparam int PIX_FIRST_POS_I = 10;
    localparam int PIX_LAST_POS_I  = ((9 + PAYLOAD_BYTES) < (PACKET_BYTES - 1)) ?
                                     (9 + PAYLOAD_BYTES) : (PACKET_BYTES - 1);

    localparam logic [POS_W-1:0] HDR_FRAME_POS = POS_W'(HDR_FRAME_POS_I);
    localparam logic [POS_W-1:0] HDR_LINE_POS  = POS_W'(HDR_LINE_POS_I);
    localparam logic [POS_W-1:0] PIX_FIRST_POS = POS_W'(PIX_FIRST_POS_I);
    localparam logic [POS_W-1:0] PIX_LAST_POS  = POS_W'(PIX_LAST_POS_I);
    localparam logic [POS_W-1:0] PACKET_END    = POS_W'(PACKET_BYTES);
    localparam logic [7:0]       LAST_LINE_NUM = 8'(LAST_LINE);

    typedef struct packed {
        logic       frame_done;
        logic [7:0] pixel_value;
        logic [8:0] column;
        logic [7:0] line_number;
        logic [6:0] frame_number;
    } slpd_result_t;

endpackage
`default_nettype wire

// File: rtl/scan_line_packet_deframer.sv
`timescale 1ns / 1ps
`default_nettype none
// A pixel byte passes the input register and then the result register to m_tvalid.
// Throughput: one byte per cycle unless a result stalls on m_tready; input and result
// registers are parted, so one byte is still taken while a finished result waits.
// Header, trailer, hunted and dropped bytes produce no result transfer.
// Reset (aresetn low, synchronous) empties both registers, clears the sync
// history and returns the block to the hunt with expected frame and line 0.
// ----------------------------------------------------------------------------
// scan_line_packet_deframer: byte stream to tagged scan line pixels
// Hunts for the sync word, checks each packet header against the expected
// frame and line, and emits every pixel of an accepted line with its frame,
// line and column.
// ----------------------------------------------------------------------------
module scan_line_packet_deframer
    import slpd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [6:0] frame_number, [14:7] line_number,
                                        // [23:15] column, [31:24] pixel_value
    output logic             m_tlast    // frame_done
);

    // Input register: one byte waiting to be processed.
    logic         in_valid_reg, in_valid_next;
    logic [7:0]   in_byte_reg;

    // Result register: one finished pixel waiting for its transfer.
    logic         out_valid_reg, out_valid_next;
    slpd_result_t out_data_reg;

    logic         advance;
    logic         in_packet;
    logic         sync_found;
    logic         res_valid;
    slpd_result_t result;

    // The held byte is processed when the result register is free or is being
    // emptied in the same cycle; the state advances only then.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    slpd_sync_hunt u_sync_hunt (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .shift_en   (advance && !in_packet),
        .data_byte  (in_byte_reg),
        .sync_found (sync_found)
    );

    slpd_packet_track u_packet_track (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (advance),
        .data_byte  (in_byte_reg),
        .sync_found (sync_found),
        .in_packet  (in_packet),
        .res_valid  (res_valid),
        .result     (result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = res_valid;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers load without reset.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (advance && res_valid) begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg.pixel_value, out_data_reg.column,
                       out_data_reg.line_number, out_data_reg.frame_number};
    assign m_tlast  = out_data_reg.frame_done;

endmodule
`default_nettype wire

// File: rtl/slpd_sync_hunt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slpd_sync_hunt: sync word detector
// Keeps the last seven hunted bytes and flags a match of the 8-byte sync word
// together with the byte now being consumed.
// ----------------------------------------------------------------------------
module slpd_sync_hunt
    import slpd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       shift_en,
    input  wire logic [7:0] data_byte,
    output logic            sync_found
);

    logic [HIST_BYTES*8-1:0] history_reg;
    logic [HIST_BYTES*8-1:0] history_next;

    assign sync_found = shift_en && ({history_reg, data_byte} == SYNC_WORD);

    // The history is cleared on a match so the next hunt starts fresh.
    always_comb begin
        history_next = history_reg;
        if (sync_found) begin
            history_next = '0;
        end else if (shift_en) begin
            history_next = {history_reg[HIST_BYTES*8-9:0], data_byte};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            history_reg <= '0;
        end else begin
            history_reg <= history_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/slpd_packet_track.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slpd_packet_track: packet position, header check and pixel tagging
// Walks one packet byte by byte, checks the header against the expected
// frame and line, and forms a pixel result for every accepted payload byte.
// ----------------------------------------------------------------------------
module slpd_packet_track
    import slpd_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   step_en,
    input  wire logic [7:0] data_byte,
    input  wire logic   sync_found,
    output logic        in_packet,
    output logic        res_valid,
    output slpd_result_t result
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             in_packet_reg, in_packet_next;
    logic [7:0]       first_hdr_reg, first_hdr_next;
    logic             accepted_reg, accepted_next;
    logic [6:0]       exp_frame_reg, exp_frame_next;
    logic [7:0]       exp_line_reg, exp_line_next;

    logic [6:0]       hdr_frame;
    logic [7:0]       hdr_line;
    logic             hdr_match;
    logic             is_pixel;
    logic             is_last_pixel;
    logic [POS_W-1:0] pos_inc;
    logic [POS_W-1:0] col_full;

    assign in_packet = in_packet_reg;

    assign hdr_frame = first_hdr_reg[7:1];
    assign hdr_line  = {data_byte[7] | first_hdr_reg[0], data_byte[6:0]};
    assign hdr_match = (exp_frame_reg == hdr_frame) && (exp_line_reg == hdr_line);

    assign is_pixel      = (pos_reg >= PIX_FIRST_POS) && (pos_reg <= PIX_LAST_POS)
                           && accepted_reg;
    assign is_last_pixel = (pos_reg == PIX_LAST_POS);
    assign pos_inc       = pos_reg + POS_W'(1);
    assign col_full      = pos_reg - PIX_FIRST_POS;

    always_comb begin
        pos_next       = pos_reg;
        in_packet_next = in_packet_reg;
        first_hdr_next = first_hdr_reg;
        accepted_next  = accepted_reg;
        exp_frame_next = exp_frame_reg;
        exp_line_next  = exp_line_reg;
        res_valid      = 1'b0;

        result.frame_number = exp_frame_reg;
        result.line_number  = exp_line_reg;
        result.column       = col_full[8:0];
        result.pixel_value  = data_byte;
        result.frame_done   = is_last_pixel && (exp_line_reg == LAST_LINE_NUM);

        if (step_en) begin
            if (!in_packet_reg) begin
                if (sync_found) begin
                    in_packet_next = 1'b1;
                    pos_next       = HDR_FRAME_POS;
                end
            end else begin
                if (pos_reg == HDR_FRAME_POS) begin
                    first_hdr_next = data_byte;
                end else if (pos_reg == HDR_LINE_POS) begin
                    // A mismatch resynchronizes to the header's frame at line 0;
                    // the line is then accepted only if it is line 0.
                    if (!hdr_match) begin
                        exp_frame_next = hdr_frame;
                        exp_line_next  = '0;
                    end
                    accepted_next = hdr_match || (hdr_line == 8'd0);
                end else if (is_pixel) begin
                    res_valid = 1'b1;
                    if (is_last_pixel) begin
                        if (exp_line_reg == LAST_LINE_NUM) begin
                            exp_frame_next = exp_frame_reg + 7'd1;
                            exp_line_next  = '0;
                        end else begin
                            exp_line_next = exp_line_reg + 8'd1;
                        end
                    end
                end

                if (pos_inc >= PACKET_END) begin
                    in_packet_next = 1'b0;
                    pos_next       = '0;
                end else begin
                    pos_next = pos_inc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            in_packet_reg <= 1'b0;
            first_hdr_reg <= '0;
            accepted_reg  <= 1'b0;
            exp_frame_reg <= '0;
            exp_line_reg  <= '0;
        end else begin
            pos_reg       <= pos_next;
            in_packet_reg <= in_packet_next;
            first_hdr_reg <= first_hdr_next;
            accepted_reg  <= accepted_next;
            exp_frame_reg <= exp_frame_next;
            exp_line_reg  <= exp_line_next;
        end
    end

endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the scan line packet deframer
// Streams sync words, headers, pixel payloads and noise into the block, keeps
// its own deframing model of frame and line tracking, and compares every pixel
// transfer against the oldest predicted pixel while both sides stall at random.
// ----------------------------------------------------------------------------
module testbench;
    import slpd_pkg::*;

    // Cycles without any transfer on either side before the run is abandoned.
    // The longest legal quiet spell is a short random stall or the tail wait.
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 16;
    localparam int PIXELS_PER_LINE = PIX_LAST_POS_I - PIX_FIRST_POS_I + 1;
    localparam int RANDOM_BYTES = 300;
    localparam int PARTIAL_PIXELS = 64;

    typedef enum logic [1:0] {
        PIX_RANDOM,
        PIX_RAMP,
        PIX_EMBED_SYNC
    } pixel_fill_e;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;

    // When set, neither the byte source nor the pixel sink inserts idle cycles.
    bit          quiet = 1'b0;
    int unsigned bytes_sent = 0;
    int unsigned mismatch_count = 0;
    int unsigned stall_cycles = 0;

    // Deframing model state, starting from the post-reset values.
    logic [63:0] hunt_history = '0;
    logic [9:0]  pkt_pos = '0;
    logic        framing = 1'b0;
    logic [7:0]  frame_hdr = '0;
    logic        line_ok = 1'b0;
    logic [6:0]  exp_frame = '0;
    logic [7:0]  exp_line = '0;

    // Pixels the block owes us, oldest first.
    slpd_result_t pending_pixels[$];

    scan_line_packet_deframer uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Advances the deframing model by one accepted byte. While hunting, the
    // byte only feeds the sync history. Inside a packet the position decides
    // whether the byte is header, pixel or trailer, and a pixel of an accepted
    // line becomes one predicted result.
    function automatic void deframe_byte(input logic [7:0] b);
        slpd_result_t px;
        logic [6:0]   hdr_frame;
        logic [7:0]   hdr_line;

        if (!framing) begin
            hunt_history = {hunt_history[55:0], b};
            if (hunt_history == SYNC_WORD) begin
                framing = 1'b1;
                pkt_pos = HDR_FRAME_POS;
                hunt_history = '0;
            end
            return;
        end

        // The low bit of the frame byte is ORed into bit 7 of the line number.
        hdr_frame = frame_hdr[7:1];
        hdr_line = b | {frame_hdr[0], 7'b0};

        if (pkt_pos == HDR_FRAME_POS) begin
            frame_hdr = b;
        end else if (pkt_pos == HDR_LINE_POS) begin
            // Any header surprise restarts tracking at line 0 of that frame,
            // so only a line 0 header can be taken on the spot.
            if (exp_frame != hdr_frame || exp_line != hdr_line) begin
                exp_frame = hdr_frame;
                exp_line = '0;
            end
            line_ok = (exp_frame == hdr_frame) && (exp_line == hdr_line);
        end else if (pkt_pos >= PIX_FIRST_POS && pkt_pos <= PIX_LAST_POS && line_ok) begin
            px.frame_number = exp_frame;
            px.line_number = exp_line;
            px.column = 9'(pkt_pos - PIX_FIRST_POS);
            px.pixel_value = b;
            px.frame_done = 1'b0;
            if (pkt_pos == PIX_LAST_POS) begin
                if (exp_line == LAST_LINE_NUM) begin
                    px.frame_done = 1'b1;
                    exp_frame = exp_frame + 7'd1;
                    exp_line = '0;
                end else begin
                    exp_line = exp_line + 8'd1;
                end
            end
            pending_pixels.push_back(px);
        end

        pkt_pos = pkt_pos + 10'd1;
        if (pkt_pos >= PACKET_END) begin
            framing = 1'b0;
            pkt_pos = '0;
        end
    endfunction

    // Offers one byte and returns at the falling edge after its transfer.
    // Must be called at a falling edge. tvalid is left high so that the next
    // byte can follow back to back.
    task automatic send_byte(input logic [7:0] b);
        while (!quiet && $urandom_range(99) < 9) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge aclk); while (!s_tready);
        deframe_byte(b);
        bytes_sent++;
        @(negedge aclk);
    endtask

    // Holds the source off until every predicted pixel has been transferred.
    task automatic drain_pixels;
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_pixels.size() != 0);
    endtask

    // Sends the sync word and the two header bytes of one packet.
    task automatic send_header(input logic [6:0] hdr_frame, input logic [7:0] hdr_line);
        logic [7:0] frame_byte;
        logic [7:0] line_byte;
        logic [1:0] bit7_route;

        // Bit 7 of the line may travel in the frame byte, the line byte or both.
        frame_byte = {hdr_frame, 1'b0};
        line_byte = {1'b0, hdr_line[6:0]};
        if (hdr_line[7]) begin
            bit7_route = 2'($urandom_range(1, 3));
            frame_byte[0] = bit7_route[0];
            line_byte[7] = bit7_route[1];
        end

        for (int i = 0; i < 8; i++) begin
            send_byte(SYNC_WORD[63 - 8 * i -: 8]);
        end
        send_byte(frame_byte);
        send_byte(line_byte);
    endtask

    // Sends one whole packet: sync word, two header bytes, payload, trailer.
    task automatic send_packet(input logic [6:0] hdr_frame, input logic [7:0] hdr_line,
                               input pixel_fill_e fill);
        logic [7:0] px;

        send_header(hdr_frame, hdr_line);

        for (int col = 0; col < PIXELS_PER_LINE; col++) begin
            case (fill)
                PIX_RAMP: begin
                    px = 8'(col);
                end
                PIX_EMBED_SYNC: begin
                    // A full sync word in the middle of the payload must not
                    // restart the packet.
                    px = (col >= 100 && col < 108) ? SYNC_WORD[63 - 8 * (col - 100) -: 8]
                                                   : 8'(col);
                end
                default: begin
                    px = 8'($urandom);
                end
            endcase
            send_byte(px);
        end

        for (int i = PIX_LAST_POS_I + 1; i < PACKET_BYTES; i++) begin
            if (fill == PIX_EMBED_SYNC) begin
                send_byte(SYNC_WORD[63 - 8 * (i - PIX_LAST_POS_I - 1) -: 8]);
            end else begin
                send_byte(8'($urandom));
            end
        end
    endtask

    // Noise, extremes and near-miss sync patterns; none of them may lock.
    task automatic test_sync_hunt;
        logic [7:0] noise[$];

        noise = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'hFF, 8'h00, 8'h5A, 8'hA5, 8'hFF,
                  8'h01, 8'h5A, 8'hA5, 8'hFF, 8'h00, 8'h5A, 8'hA5, 8'hFE, 8'h00,
                  8'h80, 8'h7F, 8'h55, 8'hAA};
        foreach (noise[i]) begin
            send_byte(noise[i]);
        end
    endtask

    // The reset expectation is frame 0 line 0, so this line is taken straight
    // away. It carries a sync word in its payload and ends with the front of
    // a sync word; the bytes after it complete that pattern, which must not
    // lock because packet bytes are never hunted.
    task automatic test_first_line;
        logic [7:0] tail[$];

        send_packet(7'd0, 8'd0, PIX_EMBED_SYNC);
        tail = '{8'h00, 8'h5A, 8'hA5, 8'hFF, 8'h00, 8'h11};
        foreach (tail[i]) begin
            send_byte(tail[i]);
        end
        drain_pixels();
    endtask

    // A header from a foreign frame resynchronizes to line 0 of that frame,
    // and since it is line 0 the line is taken. The packet runs with no idle
    // cycles on either side.
    task automatic test_header_resync;
        quiet = 1'b1;
        send_packet(7'h55, 8'd0, PIX_RANDOM);
        quiet = 1'b0;
        drain_pixels();
    endtask

    // Noise bursts and broken sync words between packets; none may lock.
    task automatic test_random_stream;
        int unsigned target;
        int unsigned pick;
        int unsigned n;

        target = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                n = $urandom_range(1, 12);
                repeat (n) send_byte(8'($urandom));
            end else if (pick < 95) begin
                n = $urandom_range(1, 7);
                for (int i = 0; i < n; i++) begin
                    send_byte(SYNC_WORD[63 - 8 * i -: 8]);
                end
                send_byte(8'h11);
            end else begin
                drain_pixels();
            end
        end
    endtask

    // A header whose line skips ahead resynchronizes to line 0 and the line is
    // dropped, so its payload must produce no transfer. The run ends inside
    // this packet.
    task automatic test_dropped_line;
        send_header(exp_frame, 8'd200);
        for (int col = 0; col < PARTIAL_PIXELS; col++) begin
            send_byte(8'($urandom));
        end
    endtask

    // The sink stalls at random unless the quiet stretch runs.
    always @(negedge aclk) begin
        m_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 9);
    end

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Every pixel transfer is matched against the oldest predicted pixel.
    always @(posedge aclk) begin : check_pixels
        slpd_result_t got;
        slpd_result_t want;

        if (aresetn && m_tvalid && m_tready) begin
            got = slpd_result_t'({m_tlast, m_tdata});
            if (pending_pixels.size() == 0) begin
                $error("pixel transfer with none expected: frame %0d line %0d column %0d",
                       got.frame_number, got.line_number, got.column);
                mismatch_count++;
            end else begin
                want = pending_pixels.pop_front();
                check_field("frame_number", 32'(want.frame_number), 32'(got.frame_number));
                check_field("line_number", 32'(want.line_number), 32'(got.line_number));
                check_field("column", 32'(want.column), 32'(got.column));
                check_field("pixel_value", 32'(want.pixel_value), 32'(got.pixel_value));
                check_field("frame_done", 32'(want.frame_done), 32'(got.frame_done));
            end
        end
    end

    // Watchdog: any transfer on either side proves the block is alive.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("scan_line_packet_deframer verification failed");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_sync_hunt();
        test_first_line();
        test_header_resync();
        test_random_stream();
        test_dropped_line();

        // Let the last pixels out, then watch a little longer for strays.
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);

        if (mismatch_count == 0 && pending_pixels.size() == 0) begin
            $display("scan_line_packet_deframer verification clean");
        end else begin
            $display("scan_line_packet_deframer verification failed");
        end
        $finish;
    end

endmodule
